### sv/ydqe_pkg.sv
// Package for the YAML double-quote escaper: command word type, codes and
// character helper functions. Depends on nothing; every other file imports it.
package ydqe_pkg;

   localparam int BODY_MAX = 6;          // longest body: backslash, 'u', four hex digits
   localparam int BODY_LEN_W = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;
   localparam int ITEM_CNT_W = 4;        // holds the largest result count of one item

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_DEL = 8'h7f;
   localparam logic [7:0] CH_ESC = 8'h1b;

   typedef enum logic [1:0] {
      CLOSE_NONE  = 2'd0,
      CLOSE_QUOTE = 2'd1,
      CLOSE_ERROR = 2'd2
   } close_type;

   // One command per accepted word that causes results.
   typedef struct packed {
      logic                          open_quote;
      logic [BODY_LEN_W-1:0]         body_len;
      logic [BODY_MAX-1:0][7:0]      body;
      close_type                     close_kind;
   } cmd_type;

   // Head of the queue as the back end sees it.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // Letter of a named escape, or zero when the byte has none.
   function automatic logic [7:0] named_escape(input logic [7:0] b);
      logic [7:0] n;
      case (b)
         8'h00:        n = 8'h30;  // '0'
         8'h07:        n = 8'h61;  // 'a'
         8'h08:        n = 8'h62;  // 'b'
         8'h09:        n = 8'h74;  // 't'
         8'h0a:        n = 8'h6e;  // 'n'
         8'h0b:        n = 8'h76;  // 'v'
         8'h0c:        n = 8'h66;  // 'f'
         8'h0d:        n = 8'h72;  // 'r'
         CH_ESC:       n = 8'h65;  // 'e'
         CH_QUOTE:     n = CH_QUOTE;
         CH_BACKSLASH: n = CH_BACKSLASH;
         default:      n = 8'h00;
      endcase
      return n;
   endfunction

   // Lowercase hex digit of a nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = 8'h30 + {4'h0, n};
      end else begin
         c = 8'h57 + {4'h0, n};
      end
      return c;
   endfunction

endpackage

### sv/ydqe_front.sv
// Front end of the escaper: strict UTF-8 decoder and classifier that turns
// each accepted word that causes results into one command. Depends on ydqe_pkg.
module ydqe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             first_of_string,
   input  logic             last_of_string,
   input  logic             empty_string,
   output logic             push,
   output ydqe_pkg::cmd_type cmd
);
   import ydqe_pkg::*;

   logic [7:0] held0_ff, held1_ff, held2_ff;
   logic [7:0] held0_in, held1_in, held2_in;
   logic [1:0] need_ff, need_in;
   logic [2:0] seqlen_ff, seqlen_in;
   logic       error_ff, error_in;

   always_comb begin
      logic        err_c;
      logic [1:0]  need_c;
      logic [2:0]  len_c;
      logic [2:0]  pos;
      logic [7:0]  lo, hi, named;
      logic [15:0] cp;
      logic        hex_esc;

      err_c = first_of_string ? 1'b0 : error_ff;
      need_c = first_of_string ? 2'd0 : need_ff;
      len_c = first_of_string ? 3'd0 : seqlen_ff;
      error_in = err_c;
      need_in = need_c;
      seqlen_in = len_c;
      held0_in = held0_ff;
      held1_in = held1_ff;
      held2_in = held2_ff;
      pos = len_c - {1'b0, need_c};
      lo = 8'h80;
      hi = 8'hbf;
      named = named_escape(in_byte);
      cp = 16'h0000;
      hex_esc = 1'b0;

      cmd = '0;
      cmd.open_quote = first_of_string;
      cmd.close_kind = CLOSE_NONE;

      if (!empty_string && !err_c) begin
         if (need_c == 2'd0) begin
            if (in_byte <= CH_DEL) begin
               if (named != 8'h00) begin
                  cmd.body[0] = CH_BACKSLASH;
                  cmd.body[1] = named;
                  cmd.body_len = 3'd2;
               end else if (in_byte < 8'h20 || in_byte == CH_DEL) begin
                  cp = {8'h00, in_byte};
                  hex_esc = 1'b1;
               end else begin
                  cmd.body[0] = in_byte;
                  cmd.body_len = 3'd1;
               end
            end else if (in_byte >= 8'hc2 && in_byte <= 8'hdf) begin
               held0_in = in_byte;
               seqlen_in = 3'd2;
               need_in = 2'd1;
            end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
               held0_in = in_byte;
               seqlen_in = 3'd3;
               need_in = 2'd2;
            end else if (in_byte >= 8'hf0 && in_byte <= 8'hf4) begin
               held0_in = in_byte;
               seqlen_in = 3'd4;
               need_in = 2'd3;
            end else begin
               error_in = 1'b1;
            end
         end else begin
            // The second byte of some leads has a narrower range.
            if (pos == 3'd1) begin
               case (held0_ff)
                  8'he0:   lo = 8'ha0;
                  8'hed:   hi = 8'h9f;
                  8'hf0:   lo = 8'h90;
                  8'hf4:   hi = 8'h8f;
                  default: begin
                     lo = 8'h80;
                     hi = 8'hbf;
                  end
               endcase
            end
            if (in_byte < lo || in_byte > hi) begin
               error_in = 1'b1;
               need_in = 2'd0;
               seqlen_in = 3'd0;
            end else begin
               need_in = need_c - 2'd1;
               if (need_in == 2'd0) begin
                  seqlen_in = 3'd0;
                  case (len_c)
                     3'd2: begin
                        cp = {5'h00, held0_ff[4:0], in_byte[5:0]};
                        if (cp >= 16'h0080 && cp <= 16'h009f) begin
                           hex_esc = 1'b1;
                        end else begin
                           cmd.body[0] = held0_ff;
                           cmd.body[1] = in_byte;
                           cmd.body_len = 3'd2;
                        end
                     end
                     3'd3: begin
                        cp = {held0_ff[3:0], held1_ff[5:0], in_byte[5:0]};
                        if (cp == 16'h2028 || cp == 16'h2029) begin
                           hex_esc = 1'b1;
                        end else begin
                           cmd.body[0] = held0_ff;
                           cmd.body[1] = held1_ff;
                           cmd.body[2] = in_byte;
                           cmd.body_len = 3'd3;
                        end
                     end
                     default: begin
                        cmd.body[0] = held0_ff;
                        cmd.body[1] = held1_ff;
                        cmd.body[2] = held2_ff;
                        cmd.body[3] = in_byte;
                        cmd.body_len = 3'd4;
                     end
                  endcase
               end else if (pos == 3'd1) begin
                  held1_in = in_byte;
               end else if (pos == 3'd2) begin
                  held2_in = in_byte;
               end
            end
         end
      end

      if (hex_esc) begin
         cmd.body[0] = CH_BACKSLASH;
         cmd.body[1] = CH_LOWER_U;
         cmd.body[2] = hex_char(cp[15:12]);
         cmd.body[3] = hex_char(cp[11:8]);
         cmd.body[4] = hex_char(cp[7:4]);
         cmd.body[5] = hex_char(cp[3:0]);
         cmd.body_len = 3'd6;
      end

      if (last_of_string) begin
         // A sequence cut off at the end of the string is invalid too.
         if (need_in != 2'd0 || error_in) begin
            cmd.close_kind = CLOSE_ERROR;
         end else begin
            cmd.close_kind = CLOSE_QUOTE;
         end
         need_in = 2'd0;
         seqlen_in = 3'd0;
         error_in = 1'b0;
      end

      push = accept && (first_of_string || last_of_string || cmd.body_len != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= 2'd0;
         seqlen_ff <= 3'd0;
         error_ff <= 1'b0;
      end else if (accept) begin
         need_ff <= need_in;
         seqlen_ff <= seqlen_in;
         error_ff <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         held2_ff <= held2_in;
      end
   end

endmodule

### sv/ydqe_queue.sv
// Two-entry command queue between the front and back ends of the escaper.
// Depends on ydqe_pkg.
module ydqe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ydqe_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              not_full,
   output ydqe_pkg::head_type head
);
   import ydqe_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      not_full = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
      head.valid = count_ff != '0;
      head.cmd = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/ydqe_back.sv
// Back end of the escaper: steps through the queue head command one output byte per
// cycle while rsp_tready allows into a registered output word. Depends on ydqe_pkg.
module ydqe_back (
   input  logic               clock,
   input  logic               reset,
   input  ydqe_pkg::head_type head,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic [2:0]         rsp_tuser
);
   import ydqe_pkg::*;

   logic [2:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        char_valid_ff, char_valid_in;
   logic        status_ff, status_in;
   logic        end_ff, end_in;
   logic        last_item_ff, last_item_in;
   logic        load;

   always_comb begin
      logic [ITEM_CNT_W-1:0] total;
      logic [2:0]            body_idx;
      logic [7:0]            body_char;

      total = ITEM_CNT_W'(head.cmd.open_quote) + ITEM_CNT_W'(head.cmd.body_len)
            + ITEM_CNT_W'(head.cmd.close_kind != CLOSE_NONE);
      body_idx = step_ff - {2'b00, head.cmd.open_quote};
      case (body_idx)
         3'd0:    body_char = head.cmd.body[0];
         3'd1:    body_char = head.cmd.body[1];
         3'd2:    body_char = head.cmd.body[2];
         3'd3:    body_char = head.cmd.body[3];
         3'd4:    body_char = head.cmd.body[4];
         3'd5:    body_char = head.cmd.body[5];
         default: body_char = 8'h00;
      endcase

      char_valid_in = 1'b1;
      status_in = 1'b0;
      end_in = 1'b0;
      if (head.cmd.open_quote && step_ff == 3'd0) begin
         char_in = CH_QUOTE;
      end else if (body_idx < head.cmd.body_len) begin
         char_in = body_char;
      end else if (head.cmd.close_kind == CLOSE_ERROR) begin
         char_in = 8'h00;
         char_valid_in = 1'b0;
         status_in = 1'b1;
         end_in = 1'b1;
      end else begin
         char_in = CH_QUOTE;
         end_in = 1'b1;
      end
      last_item_in = {1'b0, step_ff} == total - 1'b1;

      load = head.valid && (!valid_ff || rsp_tready);
      pop = load && last_item_in;
      if (load) begin
         step_in = last_item_in ? 3'd0 : step_ff + 3'd1;
         valid_in = 1'b1;
      end else begin
         step_in = step_ff;
         valid_in = valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         char_valid_ff <= char_valid_in;
         status_ff <= status_in;
         end_ff <= end_in;
         last_item_ff <= last_item_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = char_ff;
   assign rsp_tlast = end_ff;
   assign rsp_tuser = {last_item_ff, status_ff, char_valid_ff};

endmodule

### sv/yaml_double_quote_escaper_core.sv
// Top level of the YAML double-quote escaper: a UTF-8 checking front end, a
// command queue and an output sequencer. Depends on ydqe_pkg and the ydqe_ modules.
//
//   channel   direction   tdata          tuser                               tlast
//   req_      in          in_byte[7:0]   [0] first_of_string [1] empty_string last_of_string
//   rsp_      out         out_char[7:0]  [0] char_valid [1] status
//                                        [2] last_of_item                    end_of_string
//
// An input word is taken in every cycle while the two-entry command queue has
// room. Each word yields zero to eight output words, and the back end sends one
// per cycle while the output is not stalled: plain text streams at one byte per
// cycle, and an escape yields two or six output bytes.
// Reset is synchronous and active high; it clears the decoder state, the queue
// and the output valid flag. A stall on the output side holds the output word,
// fills the queue and then drops req_tready; input idling only empties the queue.
module yaml_double_quote_escaper_core (
   input  logic       clock,
   input  logic       reset,
   // Input words.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic [1:0] req_tuser,   // [0] first_of_string, [1] empty_string
   input  logic       req_tlast,   // last_of_string
   // Result words.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [2:0] rsp_tuser,   // [0] char_valid, [1] status, [2] last_of_item
   output logic       rsp_tlast    // end_of_string
);
   import ydqe_pkg::*;

   logic     accept;
   logic     push;
   logic     pop;
   logic     not_full;
   cmd_type  push_cmd;
   head_type head;

   // The front end only advances on an accepted word; the queue gates that.
   assign req_tready = not_full;
   assign accept = req_tvalid && not_full;

   // Decodes the byte, tracks the open sequence and builds the command that
   // lists the opening quote, the escaped or passed body and the closing word.
   ydqe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_byte         (req_tdata),
      .first_of_string (req_tuser[0]),
      .last_of_string  (req_tlast),
      .empty_string    (req_tuser[1]),
      .push            (push),
      .cmd             (push_cmd)
   );

   // Decouples the decoder from the output stalls.
   ydqe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .not_full (not_full),
      .head     (head)
   );

   // Walks the head command one result word per cycle while rsp_tready allows.
   ydqe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
